// ===== rtl/core/ber_tlv_tag_scanner_macros.svh =====
// assertion macros for the ber tlv tag scanner
`ifndef BER_TLV_TAG_SCANNER_MACROS_SVH
`define BER_TLV_TAG_SCANNER_MACROS_SVH

// property that must hold at every edge outside reset
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bts_pkg.sv =====
// shared constants and types of the ber tlv tag scanner
`default_nettype none

package bts_pkg;

  localparam int LENGTH_BYTES_MAX = 4;
  localparam int LEN_LEFT_W       = $clog2(LENGTH_BYTES_MAX + 1);
  localparam int TAG_EXTRA_MAX    = 4;
  localparam int TAG_CNT_W        = $clog2(TAG_EXTRA_MAX + 1);
  localparam int TAG_NUM_W        = 28;
  localparam int TAG_W            = 31;
  localparam int POS_W            = 32;
  localparam int LEN_W            = 32;
  localparam int STATUS_W         = 3;

  localparam logic [STATUS_W-1:0] ST_FOUND      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAG_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN    = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    value_offset;
    logic [LEN_W-1:0]    value_length;
  } result_t;

  typedef struct packed {
    logic head_valid;
    logic skid_valid;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bts_scan.sv =====
// per-byte tlv header decoder, tag compare and value skipping
`default_nettype none

module bts_scan
  import bts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             beat_en,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic [TAG_W-1:0] wanted_tag,
  output logic                  res_valid,
  output result_t               res
);

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_SKIP
  } phase_t;

  phase_t                phase, phase_next;
  logic [TAG_NUM_W-1:0]  tag_number, tag_number_next;
  logic [2:0]            tag_class_bits, tag_class_bits_next;
  logic [TAG_CNT_W-1:0]  tag_extra_count, tag_extra_count_next;
  logic [LEN_W-1:0]      length_value, length_value_next;
  logic [LEN_LEFT_W-1:0] length_bytes_left, length_bytes_left_next;
  logic [LEN_LEFT_W-1:0] left_dec;
  logic [LEN_W-1:0]      skip_remaining, skip_remaining_next;
  logic [LEN_W-1:0]      skip_dec;
  logic [POS_W-1:0]      byte_position, byte_position_next;
  logic                  result_given, result_given_next;
  logic                  emit;
  logic                  hdr_done;
  result_t               res_next;

  always_comb begin
    phase_next             = phase;
    tag_number_next        = tag_number;
    tag_class_bits_next    = tag_class_bits;
    tag_extra_count_next   = tag_extra_count;
    length_value_next      = length_value;
    length_bytes_left_next = length_bytes_left;
    skip_remaining_next    = skip_remaining;
    result_given_next      = result_given;
    byte_position_next     = byte_position + POS_W'(1);
    left_dec               = (length_bytes_left != '0) ? length_bytes_left - LEN_LEFT_W'(1)
                                                       : length_bytes_left;
    skip_dec               = (skip_remaining != '0) ? skip_remaining - LEN_W'(1)
                                                    : skip_remaining;
    emit                   = 1'b0;
    hdr_done               = 1'b0;
    res_next               = '{status: ST_NOT_FOUND, value_offset: '0, value_length: '0};

    if (!result_given) begin
      unique case (phase)
        PH_TAG_FIRST: begin
          tag_class_bits_next  = {data_byte[5], data_byte[7:6]};
          tag_extra_count_next = '0;
          if (data_byte[4:0] == 5'h1f) begin
            tag_number_next = '0;
            phase_next      = PH_TAG_MORE;
          end else begin
            tag_number_next = TAG_NUM_W'(data_byte[4:0]);
            phase_next      = PH_LEN_FIRST;
          end
          if (last_byte) begin
            emit            = 1'b1;
            res_next.status = ST_INCOMPLETE;
          end
        end
        PH_TAG_MORE: begin
          if (tag_extra_count >= TAG_CNT_W'(TAG_EXTRA_MAX)) begin
            emit            = 1'b1;
            res_next.status = ST_TAG_LONG;
          end else begin
            tag_extra_count_next = tag_extra_count + TAG_CNT_W'(1);
            tag_number_next      = {tag_number[TAG_NUM_W-8:0], data_byte[6:0]};
            if (!data_byte[7]) begin
              phase_next = PH_LEN_FIRST;
            end
            if (last_byte) begin
              emit            = 1'b1;
              res_next.status = ST_INCOMPLETE;
            end
          end
        end
        PH_LEN_FIRST: begin
          if (data_byte[7]) begin
            if (data_byte[6:0] > 7'(LENGTH_BYTES_MAX)) begin
              emit            = 1'b1;
              res_next.status = ST_BAD_LEN;
            end else if (data_byte[6:0] == 7'd0) begin
              length_value_next = '0;
              hdr_done          = 1'b1;
            end else begin
              length_value_next      = '0;
              length_bytes_left_next = data_byte[LEN_LEFT_W-1:0];
              phase_next             = PH_LEN_MORE;
              if (last_byte) begin
                emit            = 1'b1;
                res_next.status = ST_INCOMPLETE;
              end
            end
          end else begin
            length_value_next = LEN_W'(data_byte);
            hdr_done          = 1'b1;
          end
        end
        PH_LEN_MORE: begin
          length_value_next      = {length_value[LEN_W-9:0], data_byte};
          length_bytes_left_next = left_dec;
          if (left_dec == '0) begin
            hdr_done = 1'b1;
          end else if (last_byte) begin
            emit            = 1'b1;
            res_next.status = ST_INCOMPLETE;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_TAG_FIRST;
          end
          if (last_byte) begin
            emit            = 1'b1;
            res_next.status = ST_NOT_FOUND;
          end
        end
        default: begin
          phase_next = PH_TAG_FIRST;
        end
      endcase

      // header complete: compare tag, then report or skip the value
      if (hdr_done) begin
        if ({tag_number, tag_class_bits} == wanted_tag) begin
          emit                  = 1'b1;
          res_next.status       = ST_FOUND;
          res_next.value_offset = byte_position + POS_W'(1);
          res_next.value_length = length_value_next;
        end else begin
          if (length_value_next == '0) begin
            phase_next = PH_TAG_FIRST;
          end else begin
            skip_remaining_next = length_value_next;
            phase_next          = PH_SKIP;
          end
          if (last_byte) begin
            emit            = 1'b1;
            res_next.status = ST_NOT_FOUND;
          end
        end
      end

      if (emit) begin
        result_given_next = 1'b1;
      end
    end

    // last byte always starts a fresh stream
    if (last_byte) begin
      phase_next             = PH_TAG_FIRST;
      tag_number_next        = '0;
      tag_class_bits_next    = '0;
      tag_extra_count_next   = '0;
      length_value_next      = '0;
      length_bytes_left_next = '0;
      skip_remaining_next    = '0;
      byte_position_next     = '0;
      result_given_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_TAG_FIRST;
      tag_number        <= '0;
      tag_class_bits    <= '0;
      tag_extra_count   <= '0;
      length_value      <= '0;
      length_bytes_left <= '0;
      skip_remaining    <= '0;
      byte_position     <= '0;
      result_given      <= 1'b0;
    end else if (beat_en) begin
      phase             <= phase_next;
      tag_number        <= tag_number_next;
      tag_class_bits    <= tag_class_bits_next;
      tag_extra_count   <= tag_extra_count_next;
      length_value      <= length_value_next;
      length_bytes_left <= length_bytes_left_next;
      skip_remaining    <= skip_remaining_next;
      byte_position     <= byte_position_next;
      result_given      <= result_given_next;
    end
  end

  assign res_valid = beat_en & emit;
  assign res       = res_next;

endmodule

`default_nettype wire

// ===== rtl/core/bts_out_q.sv =====
// two-entry result buffer: output register plus skid entry
`default_nettype none

module bts_out_q
  import bts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire result_t  push_data,
  input  wire logic     pop_stall,
  output logic          head_valid,
  output result_t       head,
  output queue_status_t q_status
);

  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop = head_valid & ~pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid || pop) begin
        head_valid <= skid_valid | push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

  assign q_status = '{head_valid: head_valid, skid_valid: skid_valid};

endmodule

`default_nettype wire

// ===== rtl/core/ber_tlv_tag_scanner.sv =====
// Scans a byte stream of flat BER TLV items for the first item whose packed tag
// (class in bits 1:0, constructed in bit 2, number above) equals wanted_tag, and
// gives one result beat per stream, closed by the byte marked last_byte. One byte
// is taken every cycle unless in_stall holds; the header decode, tag compare and skip
// counter are combinational between the scanner state and a two-entry result buffer,
// which registers the result of the byte that decides it. Input stalls
// only while both buffer entries hold results that the output has not taken.
// wanted_tag is written through its own port and takes effect on the next byte.
`default_nettype none

module ber_tlv_tag_scanner
  import bts_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [TAG_W-1:0]    wanted_tag,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic [POS_W-1:0]         value_offset,
  output logic [LEN_W-1:0]         value_length
);

  `include "ber_tlv_tag_scanner_macros.svh"

  logic [TAG_W-1:0] wanted_tag_q;
  logic             beat_en;
  logic             res_valid;
  result_t          res;
  result_t          head;
  queue_status_t    q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_tag_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      wanted_tag_q <= wanted_tag;
    end
  end

  assign in_stall = q_status.skid_valid;
  assign beat_en  = in_valid & ~in_stall;

  bts_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .beat_en    (beat_en),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .wanted_tag (wanted_tag_q),
    .res_valid  (res_valid),
    .res        (res)
  );

  bts_out_q u_out_q (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .pop_stall  (out_stall),
    .head_valid (out_valid),
    .head       (head),
    .q_status   (q_status)
  );

  assign status       = head.status;
  assign value_offset = head.value_offset;
  assign value_length = head.value_length;

  // only a found beat carries offset and length
  `BTS_ASSERT(a_fields_zero, !out_valid || status == ST_FOUND || (value_offset == '0 && value_length == '0), "offset or length set on a beat that is not found")
  `BTS_ASSERT(a_status_code, !out_valid || status <= ST_BAD_LEN, "undefined status code")
  `BTS_ASSERT(a_skid_order, !in_stall || out_valid, "skid entry held with empty output register")
  `BTS_ASSERT_NEXT(a_result_lands, res_valid && !(out_valid && out_stall), out_valid, "result lost on its way to the output")

endmodule

`default_nettype wire
